@@ rtl/ecpa_pkg.sv @@
// Shared types, constants and field arithmetic helpers for the EC point unit.
`timescale 1ns / 1ps

package ecpa_pkg;

    localparam int FIELD_BITS  = 63;
    localparam int SCALAR_BITS = 64;
    localparam int CNT_W       = $clog2(FIELD_BITS);
    localparam int CMD_W       = 6;

    typedef logic [FIELD_BITS-1:0] field_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CMD_W-1:0]      cmd_t;
    typedef logic [1:0]            kind_t;

    localparam kind_t KIND_ADD = 2'd0;
    localparam kind_t KIND_MUL = 2'd1;
    localparam kind_t KIND_NEG = 2'd2;

    localparam field_t PRIME_RESET = FIELD_BITS'(3);
    localparam field_t COEFF_RESET = '0;
    localparam field_t MIN_PRIME   = FIELD_BITS'(3);

    localparam logic REG_PRIME = 1'b0;
    localparam logic REG_COEFF = 1'b1;

    // Datapath commands
    localparam cmd_t CMD_NOP        = 6'd0;
    localparam cmd_t CMD_LOAD       = 6'd1;
    localparam cmd_t CMD_RED_X1     = 6'd2;
    localparam cmd_t CMD_RED_Y1     = 6'd3;
    localparam cmd_t CMD_RED_X2     = 6'd4;
    localparam cmd_t CMD_RED_Y2     = 6'd5;
    localparam cmd_t CMD_RED_A      = 6'd6;
    localparam cmd_t CMD_SET_BAD    = 6'd7;
    localparam cmd_t CMD_W_INF      = 6'd8;
    localparam cmd_t CMD_W_NEG      = 6'd9;
    localparam cmd_t CMD_MUL_INIT   = 6'd10;
    localparam cmd_t CMD_W_ACC      = 6'd11;
    localparam cmd_t CMD_UV_ADD     = 6'd12;
    localparam cmd_t CMD_UV_ACC     = 6'd13;
    localparam cmd_t CMD_UV_DBL     = 6'd14;
    localparam cmd_t CMD_W_V        = 6'd15;
    localparam cmd_t CMD_W_U        = 6'd16;
    localparam cmd_t CMD_NUMDEN_SUB = 6'd17;
    localparam cmd_t CMD_MUL_UXUX   = 6'd18;
    localparam cmd_t CMD_MUL_3T     = 6'd19;
    localparam cmd_t CMD_NUMDEN_DBL = 6'd20;
    localparam cmd_t CMD_EUC_INIT   = 6'd21;
    localparam cmd_t CMD_DIV_EUC    = 6'd22;
    localparam cmd_t CMD_MUL_QS     = 6'd23;
    localparam cmd_t CMD_EUC_S      = 6'd24;
    localparam cmd_t CMD_MUL_LAM    = 6'd25;
    localparam cmd_t CMD_MUL_LL     = 6'd26;
    localparam cmd_t CMD_SUB_TUX    = 6'd27;
    localparam cmd_t CMD_WX         = 6'd28;
    localparam cmd_t CMD_SUB_UXWX   = 6'd29;
    localparam cmd_t CMD_MUL_LT     = 6'd30;
    localparam cmd_t CMD_WY         = 6'd31;
    localparam cmd_t CMD_ACC_W      = 6'd32;
    localparam cmd_t CMD_DBL_W      = 6'd33;
    localparam cmd_t CMD_OUT        = 6'd34;

    typedef struct packed {
        kind_t                          kind;
        field_t                         first_x;
        field_t                         first_y;
        logic                           first_is_inf;
        field_t                         second_x;
        field_t                         second_y;
        logic                           second_is_inf;
        logic signed [SCALAR_BITS-1:0]  scalar;
    } req_t;

    typedef struct packed {
        field_t result_x;
        field_t result_y;
        logic   result_is_inf;
        logic   bad_scalar;
    } rsp_t;

    typedef struct packed {
        logic  done;
        kind_t kind;
        logic  k_bad;
        logic  kmag_zero;
        logic  kmag_lsb;
        logic  dbl_inf;
        logic  u_inf;
        logic  v_inf;
        logic  eq_x;
        logic  eq_y;
        logic  eq_neg;
        logic  er_zero;
    } dp_status_t;

    function automatic field_t add_m(field_t a, field_t b, field_t m);
        logic [FIELD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[FIELD_BITS-1:0];
    endfunction

    function automatic field_t sub_m(field_t a, field_t b, field_t m);
        logic [FIELD_BITS:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + {1'b0, m} - {1'b0, b};
        end
        return s[FIELD_BITS-1:0];
    endfunction

    function automatic field_t neg_m(field_t y, field_t m);
        field_t r;
        r = (y == '0) ? '0 : m - y;
        return r;
    endfunction

endpackage

@@ rtl/ecpa_if.sv @@
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps

interface ecpa_req_if;
    logic           valid;
    logic           ready;
    ecpa_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ecpa_rsp_if;
    logic           valid;
    logic           ready;
    ecpa_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ecpa_datapath.sv @@
// Datapath: operand registers, serial mod-multiply/divide engine, output register.
`timescale 1ns / 1ps

module ecpa_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ecpa_pkg::cmd_t         cmd,
    output ecpa_pkg::dp_status_t   status,
    input  ecpa_pkg::req_t         req_data,
    output ecpa_pkg::rsp_t         rsp_data,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_index,
    input  ecpa_pkg::field_t       cfg_wdata
);

    localparam int FB = ecpa_pkg::FIELD_BITS;
    localparam int SB = ecpa_pkg::SCALAR_BITS;

    ecpa_pkg::field_t prime_reg, coeff_reg;

    ecpa_pkg::field_t m_reg, a_reg, three;
    ecpa_pkg::field_t raw_x1_reg, raw_y1_reg, raw_x2_reg, raw_y2_reg, raw_a_reg;
    ecpa_pkg::kind_t  kind_reg;
    logic [SB-1:0]    scalar_reg;
    logic [SB-2:0]    kmag_reg;
    logic             bad_reg;

    ecpa_pkg::field_t ux_reg, uy_reg, vx_reg, vy_reg, wx_reg, wy_reg;
    ecpa_pkg::field_t ax_reg, ay_reg, dx_reg, dy_reg;
    logic             ui_reg, vi_reg, wi_reg, ai_reg, di_reg;
    ecpa_pkg::field_t num_reg, den_reg, lam_reg, tt_reg;
    ecpa_pkg::field_t eo_reg, er_reg, eos_reg, es_reg;
    ecpa_pkg::rsp_t   rsp_reg;

    // Serial engine
    logic                eng_busy_reg;
    ecpa_pkg::cnt_t      cnt_reg;
    ecpa_pkg::cmd_t      lcmd_reg;
    ecpa_pkg::field_t    e_a_reg, e_b_reg;
    logic [FB:0]         e_r_reg;

    logic                is_div, long_start, eng_done, div_ge;
    ecpa_pkg::field_t    mul_dbl, mul_res, div_quo, q_red;
    logic [FB:0]         div_sh, div_rem;
    logic [SB-1:0]       k_abs;

    assign long_start = (cmd == ecpa_pkg::CMD_RED_X1) || (cmd == ecpa_pkg::CMD_RED_Y1)
        || (cmd == ecpa_pkg::CMD_RED_X2) || (cmd == ecpa_pkg::CMD_RED_Y2)
        || (cmd == ecpa_pkg::CMD_RED_A) || (cmd == ecpa_pkg::CMD_DIV_EUC)
        || (cmd == ecpa_pkg::CMD_MUL_UXUX) || (cmd == ecpa_pkg::CMD_MUL_3T)
        || (cmd == ecpa_pkg::CMD_MUL_QS) || (cmd == ecpa_pkg::CMD_MUL_LAM)
        || (cmd == ecpa_pkg::CMD_MUL_LL) || (cmd == ecpa_pkg::CMD_MUL_LT);

    assign is_div = (lcmd_reg == ecpa_pkg::CMD_RED_X1) || (lcmd_reg == ecpa_pkg::CMD_RED_Y1)
        || (lcmd_reg == ecpa_pkg::CMD_RED_X2) || (lcmd_reg == ecpa_pkg::CMD_RED_Y2)
        || (lcmd_reg == ecpa_pkg::CMD_RED_A) || (lcmd_reg == ecpa_pkg::CMD_DIV_EUC);

    // One multiplier bit per cycle: double, then conditionally add.
    assign mul_dbl = ecpa_pkg::add_m(e_r_reg[FB-1:0], e_r_reg[FB-1:0], m_reg);
    assign mul_res = e_b_reg[FB-1] ? ecpa_pkg::add_m(mul_dbl, e_a_reg, m_reg) : mul_dbl;

    // One quotient bit per cycle, restoring division.
    assign div_sh  = {e_r_reg[FB-1:0], e_b_reg[FB-1]};
    assign div_ge  = div_sh >= {1'b0, e_a_reg};
    assign div_rem = div_ge ? div_sh - {1'b0, e_a_reg} : div_sh;
    assign div_quo = {e_b_reg[FB-2:0], div_ge};
    assign q_red   = (div_quo == m_reg) ? '0 : div_quo;

    assign eng_done = eng_busy_reg && (cnt_reg == '0);
    assign three    = (m_reg == ecpa_pkg::MIN_PRIME) ? '0 : FB'(3);
    assign k_abs    = scalar_reg[SB-1] ? (~scalar_reg + 1'b1) : scalar_reg;

    always_comb
    begin
        status.done      = eng_done;
        status.kind      = kind_reg;
        status.k_bad     = scalar_reg == {1'b1, {(SB-1){1'b0}}};
        status.kmag_zero = kmag_reg == '0;
        status.kmag_lsb  = kmag_reg[0];
        status.dbl_inf   = di_reg;
        status.u_inf     = ui_reg;
        status.v_inf     = vi_reg;
        status.eq_x      = ux_reg == vx_reg;
        status.eq_y      = uy_reg == vy_reg;
        status.eq_neg    = (ux_reg == vx_reg) && (uy_reg == ecpa_pkg::neg_m(vy_reg, m_reg));
        status.er_zero   = er_reg == '0;
    end

    assign rsp_data = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg    <= ecpa_pkg::PRIME_RESET;
            coeff_reg    <= ecpa_pkg::COEFF_RESET;
            eng_busy_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == ecpa_pkg::REG_PRIME)
                begin
                    prime_reg <= cfg_wdata;
                end
                else
                begin
                    coeff_reg <= cfg_wdata;
                end
            end
            if (long_start)
            begin
                eng_busy_reg <= 1'b1;
                cnt_reg      <= ecpa_pkg::CNT_W'(FB - 1);
            end
            else if (eng_busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    eng_busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (long_start)
        begin
            lcmd_reg <= cmd;
            e_r_reg  <= '0;
        end
        else if (eng_busy_reg)
        begin
            e_r_reg <= is_div ? div_rem : {1'b0, mul_res};
            e_b_reg <= is_div ? div_quo : {e_b_reg[FB-2:0], 1'b0};
        end

        case (cmd)
            ecpa_pkg::CMD_LOAD:
            begin
                m_reg      <= (prime_reg < ecpa_pkg::MIN_PRIME) ? ecpa_pkg::MIN_PRIME : prime_reg;
                raw_a_reg  <= coeff_reg;
                raw_x1_reg <= req_data.first_x;
                raw_y1_reg <= req_data.first_y;
                raw_x2_reg <= req_data.second_x;
                raw_y2_reg <= req_data.second_y;
                di_reg     <= req_data.first_is_inf;
                vi_reg     <= req_data.second_is_inf;
                kind_reg   <= req_data.kind;
                scalar_reg <= req_data.scalar;
                bad_reg    <= 1'b0;
            end
            ecpa_pkg::CMD_RED_X1:   begin e_a_reg <= m_reg;   e_b_reg <= raw_x1_reg; end
            ecpa_pkg::CMD_RED_Y1:   begin e_a_reg <= m_reg;   e_b_reg <= raw_y1_reg; end
            ecpa_pkg::CMD_RED_X2:   begin e_a_reg <= m_reg;   e_b_reg <= raw_x2_reg; end
            ecpa_pkg::CMD_RED_Y2:   begin e_a_reg <= m_reg;   e_b_reg <= raw_y2_reg; end
            ecpa_pkg::CMD_RED_A:    begin e_a_reg <= m_reg;   e_b_reg <= raw_a_reg;  end
            ecpa_pkg::CMD_DIV_EUC:  begin e_a_reg <= er_reg;  e_b_reg <= eo_reg;     end
            ecpa_pkg::CMD_MUL_UXUX: begin e_a_reg <= ux_reg;  e_b_reg <= ux_reg;     end
            ecpa_pkg::CMD_MUL_3T:   begin e_a_reg <= three;   e_b_reg <= tt_reg;     end
            ecpa_pkg::CMD_MUL_QS:   begin e_a_reg <= tt_reg;  e_b_reg <= es_reg;     end
            ecpa_pkg::CMD_MUL_LAM:  begin e_a_reg <= num_reg; e_b_reg <= eos_reg;    end
            ecpa_pkg::CMD_MUL_LL:   begin e_a_reg <= lam_reg; e_b_reg <= lam_reg;    end
            ecpa_pkg::CMD_MUL_LT:   begin e_a_reg <= lam_reg; e_b_reg <= tt_reg;     end
            ecpa_pkg::CMD_SET_BAD:
            begin
                bad_reg <= 1'b1;
                wi_reg  <= 1'b1;
            end
            ecpa_pkg::CMD_W_INF:    wi_reg <= 1'b1;
            ecpa_pkg::CMD_W_NEG:
            begin
                wx_reg <= dx_reg;
                wy_reg <= ecpa_pkg::neg_m(dy_reg, m_reg);
                wi_reg <= di_reg;
            end
            ecpa_pkg::CMD_MUL_INIT:
            begin
                ai_reg   <= 1'b1;
                ax_reg   <= '0;
                ay_reg   <= '0;
                kmag_reg <= k_abs[SB-2:0];
                if (scalar_reg[SB-1])
                begin
                    dy_reg <= ecpa_pkg::neg_m(dy_reg, m_reg);
                end
            end
            ecpa_pkg::CMD_W_ACC:
            begin
                wx_reg <= ax_reg;
                wy_reg <= ay_reg;
                wi_reg <= ai_reg;
            end
            ecpa_pkg::CMD_UV_ADD:
            begin
                ux_reg <= dx_reg;
                uy_reg <= dy_reg;
                ui_reg <= di_reg;
            end
            ecpa_pkg::CMD_UV_ACC:
            begin
                ux_reg <= ax_reg;
                uy_reg <= ay_reg;
                ui_reg <= ai_reg;
                vx_reg <= dx_reg;
                vy_reg <= dy_reg;
                vi_reg <= di_reg;
            end
            ecpa_pkg::CMD_UV_DBL:
            begin
                ux_reg <= dx_reg;
                uy_reg <= dy_reg;
                ui_reg <= di_reg;
                vx_reg <= dx_reg;
                vy_reg <= dy_reg;
                vi_reg <= di_reg;
            end
            ecpa_pkg::CMD_W_V:
            begin
                wx_reg <= vx_reg;
                wy_reg <= vy_reg;
                wi_reg <= vi_reg;
            end
            ecpa_pkg::CMD_W_U:
            begin
                wx_reg <= ux_reg;
                wy_reg <= uy_reg;
                wi_reg <= ui_reg;
            end
            ecpa_pkg::CMD_NUMDEN_SUB:
            begin
                num_reg <= ecpa_pkg::sub_m(vy_reg, uy_reg, m_reg);
                den_reg <= ecpa_pkg::sub_m(vx_reg, ux_reg, m_reg);
            end
            ecpa_pkg::CMD_NUMDEN_DBL:
            begin
                num_reg <= ecpa_pkg::add_m(tt_reg, a_reg, m_reg);
                den_reg <= ecpa_pkg::add_m(uy_reg, uy_reg, m_reg);
            end
            ecpa_pkg::CMD_EUC_INIT:
            begin
                eo_reg  <= den_reg;
                er_reg  <= m_reg;
                eos_reg <= FB'(1);
                es_reg  <= '0;
            end
            ecpa_pkg::CMD_EUC_S:
            begin
                es_reg  <= ecpa_pkg::sub_m(eos_reg, tt_reg, m_reg);
                eos_reg <= es_reg;
            end
            ecpa_pkg::CMD_SUB_TUX:  tt_reg <= ecpa_pkg::sub_m(tt_reg, ux_reg, m_reg);
            ecpa_pkg::CMD_WX:       wx_reg <= ecpa_pkg::sub_m(tt_reg, vx_reg, m_reg);
            ecpa_pkg::CMD_SUB_UXWX: tt_reg <= ecpa_pkg::sub_m(ux_reg, wx_reg, m_reg);
            ecpa_pkg::CMD_WY:
            begin
                wy_reg <= ecpa_pkg::sub_m(tt_reg, uy_reg, m_reg);
                wi_reg <= 1'b0;
            end
            ecpa_pkg::CMD_ACC_W:
            begin
                ax_reg <= wx_reg;
                ay_reg <= wy_reg;
                ai_reg <= wi_reg;
            end
            ecpa_pkg::CMD_DBL_W:
            begin
                dx_reg   <= wx_reg;
                dy_reg   <= wy_reg;
                di_reg   <= wi_reg;
                kmag_reg <= kmag_reg >> 1;
            end
            ecpa_pkg::CMD_OUT:
            begin
                rsp_reg.result_x      <= wi_reg ? '0 : wx_reg;
                rsp_reg.result_y      <= wi_reg ? '0 : wy_reg;
                rsp_reg.result_is_inf <= wi_reg;
                rsp_reg.bad_scalar    <= bad_reg;
            end
            default:
            begin
            end
        endcase

        // Write back the engine result on its last step.
        if (eng_done)
        begin
            case (lcmd_reg)
                ecpa_pkg::CMD_RED_X1: dx_reg <= div_rem[FB-1:0];
                ecpa_pkg::CMD_RED_Y1: dy_reg <= div_rem[FB-1:0];
                ecpa_pkg::CMD_RED_X2: vx_reg <= div_rem[FB-1:0];
                ecpa_pkg::CMD_RED_Y2: vy_reg <= div_rem[FB-1:0];
                ecpa_pkg::CMD_RED_A:  a_reg  <= div_rem[FB-1:0];
                ecpa_pkg::CMD_DIV_EUC:
                begin
                    eo_reg <= er_reg;
                    er_reg <= div_rem[FB-1:0];
                    tt_reg <= q_red;
                end
                ecpa_pkg::CMD_MUL_LAM: lam_reg <= mul_res;
                default:               tt_reg  <= mul_res;
            endcase
        end
    end

endmodule

@@ rtl/ecpa_ctrl.sv @@
// Controller state machine sequencing reductions, point additions and the scalar loop.
`timescale 1ns / 1ps

module ecpa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output ecpa_pkg::cmd_t        cmd,
    input  ecpa_pkg::dp_status_t  status
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RX1  = 5'd1;
    localparam logic [4:0] S_RY1  = 5'd2;
    localparam logic [4:0] S_RX2  = 5'd3;
    localparam logic [4:0] S_RY2  = 5'd4;
    localparam logic [4:0] S_RA   = 5'd5;
    localparam logic [4:0] S_DISP = 5'd6;
    localparam logic [4:0] S_LOOP = 5'd7;
    localparam logic [4:0] S_DBL  = 5'd8;
    localparam logic [4:0] S_ADD  = 5'd9;
    localparam logic [4:0] S_DB1  = 5'd10;
    localparam logic [4:0] S_DB2  = 5'd11;
    localparam logic [4:0] S_DB3  = 5'd12;
    localparam logic [4:0] S_INV0 = 5'd13;
    localparam logic [4:0] S_INV1 = 5'd14;
    localparam logic [4:0] S_INV2 = 5'd15;
    localparam logic [4:0] S_INV3 = 5'd16;
    localparam logic [4:0] S_LAM  = 5'd17;
    localparam logic [4:0] S_X1   = 5'd18;
    localparam logic [4:0] S_X2   = 5'd19;
    localparam logic [4:0] S_X3   = 5'd20;
    localparam logic [4:0] S_Y1   = 5'd21;
    localparam logic [4:0] S_Y2   = 5'd22;
    localparam logic [4:0] S_Y3   = 5'd23;
    localparam logic [4:0] S_AEND = 5'd24;
    localparam logic [4:0] S_FIN  = 5'd25;

    localparam logic [1:0] PH_ADD = 2'd0;
    localparam logic [1:0] PH_ACC = 2'd1;
    localparam logic [1:0] PH_DBL = 2'd2;

    logic [4:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       issued_reg, issued_next;
    logic       valid_reg, valid_next;

    logic           long_en;
    ecpa_pkg::cmd_t long_cmd;
    logic [4:0]     long_nxt;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        issued_next = issued_reg;
        valid_next  = valid_reg && !rsp_ready;
        cmd         = ecpa_pkg::CMD_NOP;
        long_en     = 1'b0;
        long_cmd    = ecpa_pkg::CMD_NOP;
        long_nxt    = state_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd        = ecpa_pkg::CMD_LOAD;
                    state_next = S_RX1;
                end
            end
            S_RX1: begin long_en = 1'b1; long_cmd = ecpa_pkg::CMD_RED_X1; long_nxt = S_RY1; end
            S_RY1: begin long_en = 1'b1; long_cmd = ecpa_pkg::CMD_RED_Y1; long_nxt = S_RX2; end
            S_RX2: begin long_en = 1'b1; long_cmd = ecpa_pkg::CMD_RED_X2; long_nxt = S_RY2; end
            S_RY2: begin long_en = 1'b1; long_cmd = ecpa_pkg::CMD_RED_Y2; long_nxt = S_RA;  end
            S_RA:  begin long_en = 1'b1; long_cmd = ecpa_pkg::CMD_RED_A;  long_nxt = S_DISP; end
            S_DISP:
            begin
                case (status.kind)
                    ecpa_pkg::KIND_ADD:
                    begin
                        cmd        = ecpa_pkg::CMD_UV_ADD;
                        phase_next = PH_ADD;
                        state_next = S_ADD;
                    end
                    ecpa_pkg::KIND_MUL:
                    begin
                        if (status.k_bad)
                        begin
                            cmd        = ecpa_pkg::CMD_SET_BAD;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd        = ecpa_pkg::CMD_MUL_INIT;
                            state_next = S_LOOP;
                        end
                    end
                    ecpa_pkg::KIND_NEG:
                    begin
                        cmd        = ecpa_pkg::CMD_W_NEG;
                        state_next = S_FIN;
                    end
                    default:
                    begin
                        cmd        = ecpa_pkg::CMD_W_INF;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_LOOP:
            begin
                if (status.kmag_zero || status.dbl_inf)
                begin
                    cmd        = ecpa_pkg::CMD_W_ACC;
                    state_next = S_FIN;
                end
                else if (status.kmag_lsb)
                begin
                    cmd        = ecpa_pkg::CMD_UV_ACC;
                    phase_next = PH_ACC;
                    state_next = S_ADD;
                end
                else
                begin
                    state_next = S_DBL;
                end
            end
            S_DBL:
            begin
                cmd        = ecpa_pkg::CMD_UV_DBL;
                phase_next = PH_DBL;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (status.u_inf)
                begin
                    cmd        = ecpa_pkg::CMD_W_V;
                    state_next = S_AEND;
                end
                else if (status.v_inf)
                begin
                    cmd        = ecpa_pkg::CMD_W_U;
                    state_next = S_AEND;
                end
                else if (status.eq_neg)
                begin
                    cmd        = ecpa_pkg::CMD_W_INF;
                    state_next = S_AEND;
                end
                else if (status.eq_x && status.eq_y)
                begin
                    state_next = S_DB1;
                end
                else if (status.eq_x)
                begin
                    cmd        = ecpa_pkg::CMD_W_INF;
                    state_next = S_AEND;
                end
                else
                begin
                    cmd        = ecpa_pkg::CMD_NUMDEN_SUB;
                    state_next = S_INV0;
                end
            end
            S_DB1: begin long_en = 1'b1; long_cmd = ecpa_pkg::CMD_MUL_UXUX; long_nxt = S_DB2; end
            S_DB2: begin long_en = 1'b1; long_cmd = ecpa_pkg::CMD_MUL_3T;   long_nxt = S_DB3; end
            S_DB3:
            begin
                cmd        = ecpa_pkg::CMD_NUMDEN_DBL;
                state_next = S_INV0;
            end
            S_INV0:
            begin
                cmd        = ecpa_pkg::CMD_EUC_INIT;
                state_next = S_INV1;
            end
            S_INV1:
            begin
                if (!issued_reg && status.er_zero)
                begin
                    state_next = S_LAM;
                end
                else
                begin
                    long_en  = 1'b1;
                    long_cmd = ecpa_pkg::CMD_DIV_EUC;
                    long_nxt = S_INV2;
                end
            end
            S_INV2: begin long_en = 1'b1; long_cmd = ecpa_pkg::CMD_MUL_QS; long_nxt = S_INV3; end
            S_INV3:
            begin
                cmd        = ecpa_pkg::CMD_EUC_S;
                state_next = S_INV1;
            end
            S_LAM: begin long_en = 1'b1; long_cmd = ecpa_pkg::CMD_MUL_LAM; long_nxt = S_X1; end
            S_X1:  begin long_en = 1'b1; long_cmd = ecpa_pkg::CMD_MUL_LL;  long_nxt = S_X2; end
            S_X2:
            begin
                cmd        = ecpa_pkg::CMD_SUB_TUX;
                state_next = S_X3;
            end
            S_X3:
            begin
                cmd        = ecpa_pkg::CMD_WX;
                state_next = S_Y1;
            end
            S_Y1:
            begin
                cmd        = ecpa_pkg::CMD_SUB_UXWX;
                state_next = S_Y2;
            end
            S_Y2: begin long_en = 1'b1; long_cmd = ecpa_pkg::CMD_MUL_LT; long_nxt = S_Y3; end
            S_Y3:
            begin
                cmd        = ecpa_pkg::CMD_WY;
                state_next = S_AEND;
            end
            S_AEND:
            begin
                case (phase_reg)
                    PH_ACC:
                    begin
                        cmd        = ecpa_pkg::CMD_ACC_W;
                        state_next = S_DBL;
                    end
                    PH_DBL:
                    begin
                        cmd        = ecpa_pkg::CMD_DBL_W;
                        state_next = S_LOOP;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_FIN:
            begin
                if (!valid_reg || rsp_ready)
                begin
                    cmd        = ecpa_pkg::CMD_OUT;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Multi-cycle engine operations: issue once, then wait for completion.
        if (long_en)
        begin
            if (!issued_reg)
            begin
                cmd         = long_cmd;
                issued_next = 1'b1;
            end
            else if (status.done)
            begin
                issued_next = 1'b0;
                state_next  = long_nxt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_ADD;
            issued_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            issued_reg <= issued_next;
            valid_reg  <= valid_next;
        end
    end

endmodule

@@ rtl/ec_point_arith_unit_top.sv @@
// Top level of the elliptic-curve point unit: controller, datapath and channels.
`timescale 1ns / 1ps
// Operation: five operand reductions, then per point addition three (chord) or five
// (tangent) modular multiplies, plus one Euclid round per quotient step. Scalar
// multiply runs up to two point additions per magnitude bit, so its latency is set by
// the single shared bit-serial multiply/divide engine. Throughput: one transaction at
// a time; a new request is taken while a result waits. Reset (rst_n, asynchronous,
// active low) clears control, prime to 3 and coefficient to 0.

module ec_point_arith_unit_top (
    input  logic                 clk,
    input  logic                 rst_n,
    ecpa_req_if.sink             req,
    ecpa_rsp_if.source           rsp,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  ecpa_pkg::field_t     cfg_wdata
);

    // The controller issues one command per cycle; the datapath reports comparisons,
    // operation kind and engine completion back through the status struct.
    ecpa_pkg::cmd_t       cmd;
    ecpa_pkg::dp_status_t status;
    logic                 req_ready;
    logic                 rsp_valid;
    ecpa_pkg::rsp_t       rsp_data;

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.data  = rsp_data;

    ecpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath also holds the configuration registers and the response register,
    // so a finished transaction can wait on the output while the next one is loaded.
    ecpa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_data  (req.data),
        .rsp_data  (rsp_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

@@ rtl/ecpa_checker.sv @@
// Port-level assertions for the EC point unit and their bind to the top level.
`timescale 1ns / 1ps

module ecpa_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input ecpa_pkg::field_t rsp_x,
    input ecpa_pkg::field_t rsp_y,
    input logic             rsp_inf,
    input logic             rsp_bad
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_inf |-> (rsp_x == '0) && (rsp_y == '0))
        else $error("infinity with nonzero coordinates");

    a_bad_inf: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_bad |-> rsp_inf)
        else $error("bad scalar without infinity");

endmodule

bind ec_point_arith_unit_top ecpa_checker u_ecpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_x     (rsp.data.result_x),
    .rsp_y     (rsp.data.result_y),
    .rsp_inf   (rsp.data.result_is_inf),
    .rsp_bad   (rsp.data.bad_scalar)
);

@@ dv/ec_point_arith_unit_top_tb.sv @@
// Testbench for the elliptic-curve point unit: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module ec_point_arith_unit_top_tb;

    typedef logic [63:0] word_t;

    typedef struct {
        word_t x;
        word_t y;
        bit    inf;
    } point_s;

    // One row of the directed table; when has_exp is set the row carries an expected
    // result that can be read straight off the specification.
    typedef struct {
        ecpa_pkg::req_t req;
        bit             has_exp;
        ecpa_pkg::rsp_t exp;
    } vector_s;

    // Per-phase settings: register values, idle percentages, the number of items and a big-scalar flag.
    typedef struct {
        word_t prime;
        word_t coeff;
        int    send_idle;
        int    recv_stall;
        int    count;
        bit    big_scalars;
    } phase_s;

    localparam ecpa_pkg::kind_t KIND_NONE = 2'd3;
    localparam int    HOLD_CYCLES   = 100_000;
    localparam int    IDLE_LIMIT    = 6_000_000;
    localparam int    DRAIN_CYCLES  = 500;
    localparam word_t MASK63        = 64'h7fff_ffff_ffff_ffff;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic             cfg_index;
    ecpa_pkg::field_t cfg_wdata;

    ecpa_req_if req ();
    ecpa_rsp_if rsp ();

    ec_point_arith_unit_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // The testbench keeps its own copy of the two registers, updated on every write.
    word_t prime_copy;
    word_t coeff_copy;

    ecpa_pkg::rsp_t pending_points[$];
    int    mismatches;
    int    send_idle_pct;
    int    recv_stall_pct;
    int    hold_cnt;
    bit    hold_request;
    int    quiet_cycles;

    vector_s directed[$];

    // ---------------------------------------------------------------------------------
    // Field arithmetic used by the point predictor. All values are held in 64 bits so
    // that a sum of two reduced operands below a 63-bit modulus never wraps.
    // ---------------------------------------------------------------------------------
    function automatic word_t fadd(word_t a, word_t b, word_t m);
        word_t s;
        s = a + b;
        return (s >= m) ? s - m : s;
    endfunction

    function automatic word_t fsub(word_t a, word_t b, word_t m);
        return (a >= b) ? a - b : a + (m - b);
    endfunction

    // Shift-and-add product, most significant multiplier bit first.
    function automatic word_t fmul(word_t a, word_t b, word_t m);
        word_t r;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = fadd(r, r, m);
            if (b[i])
            begin
                r = fadd(r, a, m);
            end
        end
        return r;
    endfunction

    // Extended Euclid; for a composite modulus it yields whatever the iteration leaves.
    function automatic word_t finv(word_t a, word_t m);
        word_t old_r, r, old_s, s, q, t;
        old_r = a;
        r     = m;
        old_s = 64'd1;
        s     = '0;
        while (r != 0)
        begin
            q     = old_r / r;
            t     = r;
            r     = old_r % r;
            old_r = t;
            t     = s;
            s     = fsub(old_s, fmul(q % m, s, m), m);
            old_s = t;
        end
        return old_s;
    endfunction

    function automatic point_s point_at_inf();
        point_s r;
        r.x   = '0;
        r.y   = '0;
        r.inf = 1'b1;
        return r;
    endfunction

    function automatic point_s point_neg(point_s p, word_t m);
        if (p.inf)
        begin
            return point_at_inf();
        end
        p.y = (p.y == 0) ? '0 : m - p.y;
        return p;
    endfunction

    // Affine addition with the infinity, inverse and doubling cases.
    function automatic point_s point_add(point_s p, point_s q, word_t m, word_t a);
        word_t  slope, num, den;
        point_s r;
        if (p.inf)
        begin
            return q;
        end
        if (q.inf)
        begin
            return p;
        end
        if (p.x == q.x && p.y == ((q.y == 0) ? 64'd0 : m - q.y))
        begin
            return point_at_inf();
        end
        if (p.x == q.x && p.y == q.y)
        begin
            num = fadd(fmul(64'd3 % m, fmul(p.x, p.x, m), m), a, m);
            den = fadd(p.y, p.y, m);
        end
        else
        begin
            if (p.x == q.x)
            begin
                return point_at_inf();
            end
            num = fsub(q.y, p.y, m);
            den = fsub(q.x, p.x, m);
        end
        slope = fmul(num, finv(den, m), m);
        r.inf = 1'b0;
        r.x   = fsub(fsub(fmul(slope, slope, m), p.x, m), q.x, m);
        r.y   = fsub(fmul(slope, fsub(p.x, r.x, m), m), p.y, m);
        return r;
    endfunction

    // Works out the result point of one request under the current register copy.
    function automatic ecpa_pkg::rsp_t predict_point(ecpa_pkg::req_t d);
        word_t          m, a, k, mag;
        point_s         p, q, r, acc, dbl;
        bit             bad;
        ecpa_pkg::rsp_t o;
        m     = (prime_copy & MASK63) < 3 ? 64'd3 : (prime_copy & MASK63);
        a     = (coeff_copy & MASK63) % m;
        bad   = 1'b0;
        p.x   = {1'b0, d.first_x} % m;
        p.y   = {1'b0, d.first_y} % m;
        p.inf = d.first_is_inf;
        q.x   = {1'b0, d.second_x} % m;
        q.y   = {1'b0, d.second_y} % m;
        q.inf = d.second_is_inf;
        r     = point_at_inf();
        case (d.kind)
            ecpa_pkg::KIND_ADD: r = point_add(p, q, m, a);
            ecpa_pkg::KIND_MUL:
            begin
                k = d.scalar;
                if (k == 64'h8000_0000_0000_0000)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    mag = k;
                    if (k[63])
                    begin
                        p   = point_neg(p, m);
                        mag = -k;
                    end
                    acc = point_at_inf();
                    dbl = p;
                    while (mag != 0 && !dbl.inf)
                    begin
                        if (mag[0])
                        begin
                            acc = point_add(acc, dbl, m, a);
                        end
                        dbl = point_add(dbl, dbl, m, a);
                        mag = mag >> 1;
                    end
                    r = acc;
                end
            end
            ecpa_pkg::KIND_NEG: r = point_neg(p, m);
            default:  r = point_at_inf();
        endcase
        if (r.inf)
        begin
            r.x = '0;
            r.y = '0;
        end
        o.result_x      = r.x[ecpa_pkg::FIELD_BITS-1:0];
        o.result_y      = r.y[ecpa_pkg::FIELD_BITS-1:0];
        o.result_is_inf = r.inf;
        o.bad_scalar    = bad;
        return o;
    endfunction

    function automatic ecpa_pkg::req_t make_req(ecpa_pkg::kind_t kind, word_t x1, word_t y1,
                                                bit i1, word_t x2, word_t y2, bit i2,
                                                word_t k);
        ecpa_pkg::req_t d;
        d.kind          = kind;
        d.first_x       = x1[ecpa_pkg::FIELD_BITS-1:0];
        d.first_y       = y1[ecpa_pkg::FIELD_BITS-1:0];
        d.first_is_inf  = i1;
        d.second_x      = x2[ecpa_pkg::FIELD_BITS-1:0];
        d.second_y      = y2[ecpa_pkg::FIELD_BITS-1:0];
        d.second_is_inf = i2;
        d.scalar        = k;
        return d;
    endfunction

    function automatic ecpa_pkg::rsp_t make_rsp(word_t x, word_t y, bit inf, bit bad);
        ecpa_pkg::rsp_t o;
        o.result_x      = x[ecpa_pkg::FIELD_BITS-1:0];
        o.result_y      = y[ecpa_pkg::FIELD_BITS-1:0];
        o.result_is_inf = inf;
        o.bad_scalar    = bad;
        return o;
    endfunction

    function automatic word_t raw_coord();
        return {$urandom, $urandom} & MASK63;
    endfunction

    // Random request. Most multiplies use a few magnitude bits so that a run stays
    // within reach; full-width scalars appear only where the phase allows them.
    function automatic ecpa_pkg::req_t random_req(bit big_scalars);
        word_t           m, x1, y1, x2, y2, k, py;
        int              pick, nbits;
        ecpa_pkg::kind_t kind;
        m    = (prime_copy & MASK63) < 3 ? 64'd3 : (prime_copy & MASK63);
        pick = $urandom_range(0, 99);
        kind = (pick < 40) ? ecpa_pkg::KIND_ADD : (pick < 70) ? ecpa_pkg::KIND_MUL :
               (pick < 95) ? ecpa_pkg::KIND_NEG : KIND_NONE;
        x1 = raw_coord();
        y1 = raw_coord();
        x2 = raw_coord();
        y2 = raw_coord();
        case ($urandom_range(0, 2))
            0:
            begin
                x2 = x1;
                y2 = y1;
            end
            1:
            begin
                py = y1 % m;
                x2 = x1 % m;
                y2 = (py == 0) ? 64'd0 : m - py;
            end
            default: ;
        endcase
        if (big_scalars && $urandom_range(0, 11) == 0)
        begin
            k = {$urandom, $urandom};
        end
        else
        begin
            nbits = $urandom_range(1, 6);
            k     = $urandom_range(0, (1 << nbits) - 1);
            if ($urandom_range(0, 1))
            begin
                k = -k;
            end
        end
        return make_req(kind, x1, y1, ($urandom_range(0, 7) == 0), x2, y2,
                        ($urandom_range(0, 7) == 0), k);
    endfunction

    // ---------------------------------------------------------------------------------
    // Clock and reset. Reset is applied once and then held released.
    // ---------------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.data       = '0;
        rsp.ready      = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = ecpa_pkg::REG_PRIME;
        cfg_wdata      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cnt       = 0;
        hold_request   = 1'b0;
        mismatches     = 0;
        quiet_cycles   = 0;
        prime_copy     = 64'd3;
        coeff_copy     = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------------------------
    // Response side. The ready line is redrawn each cycle from the stall percentage of
    // the current phase. A hold-off request from the stimulus process makes this process
    // keep ready low for a long stretch, counted here, so the unit fills up and its
    // request side backs up while the sender keeps offering transactions.
    // ---------------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_cnt     = HOLD_CYCLES;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt  = hold_cnt - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Scoreboard: every accepted response transaction is matched against the oldest
    // expected point, field by field.
    always @(posedge clk)
    begin
        ecpa_pkg::rsp_t want;
        ecpa_pkg::rsp_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = rsp.data;
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: unexpected response x=%h y=%h inf=%b bad=%b",
                             got.result_x, got.result_y, got.result_is_inf,
                             got.bad_scalar);
                end
            end
            else
            begin
                want = pending_points.pop_front();
                if (got.result_x !== want.result_x || got.result_y !== want.result_y ||
                    got.result_is_inf !== want.result_is_inf ||
                    got.bad_scalar !== want.bad_scalar)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: expected x=%h y=%h inf=%b bad=%b", want.result_x,
                                 want.result_y, want.result_is_inf, want.bad_scalar);
                        $display("       actual   x=%h y=%h inf=%b bad=%b", got.result_x,
                                 got.result_y, got.result_is_inf, got.bad_scalar);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel completes a transaction. The
    // limit covers a full-width scalar multiply behind the long response hold-off.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
                $display("** ec_point_arith_unit_top: FAILED **");
                $finish;
            end
        end
    end

    // Offers one request and waits until it is accepted. The expectation is queued at
    // the accepting edge, so it always reflects the register copy in force then.
    task automatic send_request(ecpa_pkg::req_t d, bit has_exp, ecpa_pkg::rsp_t exp);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= d;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        pending_points.push_back(has_exp ? exp : predict_point(d));
    endtask

    // Waits with the request side idle until every expected point has come back.
    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic write_register(logic index, word_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value[ecpa_pkg::FIELD_BITS-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (index == ecpa_pkg::REG_PRIME)
        begin
            prime_copy = value & MASK63;
        end
        else
        begin
            coeff_copy = value & MASK63;
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Stimulus. The directed table runs under the reset register values (p = 3, a = 0),
    // where small hand-picked points exercise every special case cheaply. The random
    // phases then walk through register settings from a modulus below the minimum up
    // to the largest 63-bit value, each setting its idle and stall percentages.
    // ---------------------------------------------------------------------------------
    initial
    begin
        phase_s         phases[$];
        ecpa_pkg::rsp_t none;
        none = '0;

        // Trivial cases whose answer is read straight off the specification.
        directed.push_back('{make_req(ecpa_pkg::KIND_ADD, 0, 0, 1, 0, 0, 1, 0), 1,
                             make_rsp(0, 0, 1, 0)});
        directed.push_back('{make_req(ecpa_pkg::KIND_MUL, 1, 1, 0, 0, 0, 0,
                                      64'h8000_0000_0000_0000), 1, make_rsp(0, 0, 1, 1)});
        directed.push_back('{make_req(ecpa_pkg::KIND_MUL, 1, 1, 0, 0, 0, 0, 0), 1,
                             make_rsp(0, 0, 1, 0)});
        directed.push_back('{make_req(KIND_NONE, MASK63, MASK63, 0, MASK63, MASK63, 0,
                                      64'hffff_ffff_ffff_ffff), 1, make_rsp(0, 0, 1, 0)});
        directed.push_back('{make_req(ecpa_pkg::KIND_NEG, 2, 2, 1, 0, 0, 0, 0), 1,
                             make_rsp(0, 0, 1, 0)});
        directed.push_back('{make_req(ecpa_pkg::KIND_NEG, 1, 1, 0, 0, 0, 0, 0), 1,
                             make_rsp(1, 2, 0, 0)});
        // Unreduced operands, one side at infinity, inverse pair, doubling.
        directed.push_back('{make_req(ecpa_pkg::KIND_ADD, MASK63, MASK63, 0, 0, 0, 1, 0), 0,
                             none});
        directed.push_back('{make_req(ecpa_pkg::KIND_ADD, 9, 9, 1, 5, 4, 0, 0), 0, none});
        directed.push_back('{make_req(ecpa_pkg::KIND_ADD, 1, 1, 0, 1, 2, 0, 0), 0, none});
        directed.push_back('{make_req(ecpa_pkg::KIND_ADD, 1, 1, 0, 4, 1, 0, 0), 0, none});
        directed.push_back('{make_req(ecpa_pkg::KIND_ADD, 0, 0, 0, 1, 0, 0, 0), 0, none});
        directed.push_back('{make_req(ecpa_pkg::KIND_ADD, 0, 1, 0, 0, 0, 0, 0), 0, none});
        directed.push_back('{make_req(ecpa_pkg::KIND_ADD, 2, 0, 0, 2, 0, 0, 0), 0, none});
        directed.push_back('{make_req(ecpa_pkg::KIND_NEG, 2, 0, 0, 0, 0, 0, 0), 0, none});
        // Scalar extremes and signs.
        directed.push_back('{make_req(ecpa_pkg::KIND_MUL, 1, 1, 0, 0, 0, 0, 1), 0, none});
        directed.push_back('{make_req(ecpa_pkg::KIND_MUL, 1, 1, 0, 0, 0, 0, 2), 0, none});
        directed.push_back('{make_req(ecpa_pkg::KIND_MUL, 1, 1, 0, 0, 0, 0,
                                      64'hffff_ffff_ffff_ffff), 0, none});
        directed.push_back('{make_req(ecpa_pkg::KIND_MUL, 2, 1, 0, 0, 0, 0,
                                      64'h7fff_ffff_ffff_ffff), 0, none});
        directed.push_back('{make_req(ecpa_pkg::KIND_MUL, 2, 1, 0, 0, 0, 0,
                                      64'h8000_0000_0000_0001), 0, none});
        directed.push_back('{make_req(ecpa_pkg::KIND_MUL, 1, 1, 1, 0, 0, 0, 5), 0, none});

        phases.push_back('{64'd0, MASK63, 46, 0, 12, 1});
        phases.push_back('{64'd10007, 64'd5, 0, 46, 22, 1});
        phases.push_back('{64'd2147483647, raw_coord(), 9, 9, 22, 0});
        phases.push_back('{64'h1fff_ffff_ffff_ffff, 64'd2, 0, 0, 18, 0});
        phases.push_back('{MASK63, 64'd0, 46, 0, 10, 0});

        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end

        foreach (directed[i])
        begin
            send_request(directed[i].req, directed[i].has_exp, directed[i].exp);
        end
        wait_drained();

        foreach (phases[p])
        begin
            write_register(ecpa_pkg::REG_PRIME, phases[p].prime);
            write_register(ecpa_pkg::REG_COEFF, phases[p].coeff);
            send_idle_pct  = phases[p].send_idle;
            recv_stall_pct = phases[p].recv_stall;
            for (int n = 0; n < phases[p].count; n++)
            begin
                // In the receiver-stall phase the response side is held off for a
                // long stretch right away, so that the unit backs up its input.
                if (p == 1 && n == 0)
                begin
                    hold_request = 1'b1;
                end
                // Midway through the mixed phase, the sender pauses until the unit
                // has returned every outstanding point.
                if (p == 2 && n == phases[p].count / 2)
                begin
                    wait_drained();
                end
                send_request(random_req(phases[p].big_scalars), 1'b0, none);
            end
            wait_drained();
        end

        // Let any stray response show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_points.size() == 0)
        begin
            $display("** ec_point_arith_unit_top: PASSED **");
        end
        else
        begin
            $display("** ec_point_arith_unit_top: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ecpa_pkg.sv
rtl/ecpa_if.sv
rtl/ecpa_datapath.sv
rtl/ecpa_ctrl.sv
rtl/ec_point_arith_unit_top.sv
rtl/ecpa_checker.sv
dv/ec_point_arith_unit_top_tb.sv
